// ----- rtl/morse_key_decoder_top_assert.svh -----
// Assertion macros used by the checker file of the Morse key decoder.
`ifndef MORSE_KEY_DECODER_TOP_ASSERT_SVH
`define MORSE_KEY_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge of clk, off during reset.
`define MKD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising edge of clk, off during reset.
`define MKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/mkd_pkg.sv -----
package mkd_pkg;

  localparam int TickW = 12;
  localparam int CountW = 8;
  localparam int CodeW = 7;
  localparam int DotLimitW = 10;
  localparam int LetterGapW = 10;
  localparam int WordGapW = 12;
  localparam int CfgDataW = 12;

  localparam int SymbolSlotsDefault = 9;
  localparam int MessageCapacity = 128;

  localparam logic [TickW-1:0] TickMax = '1;
  localparam logic [DotLimitW-1:0] DotLimitReset = 10'd30;
  localparam logic [LetterGapW-1:0] LetterGapReset = 10'd50;
  localparam logic [WordGapW-1:0] WordGapReset = 12'd150;

  localparam logic [CodeW-1:0] UnknownCode = 7'h61;
  localparam logic [CodeW-1:0] LetterBase = 7'h41;
  localparam logic [CodeW-1:0] DigitBase = 7'h30;
  localparam int MaxCodeLen = 5;
  localparam int CodeEntries = 36;
  localparam int LetterEntries = 26;

  // Each entry is {length, symbols}; symbol i sits in bit i, a dash is 1.
  localparam logic [7:0] CodeTable [CodeEntries] = '{
    {3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001},
    {3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000},
    {3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010},
    {3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
    {3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
    {3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001},
    {3'd4, 5'b01101}, {3'd4, 5'b00011},
    {3'd5, 5'b11111}, {3'd5, 5'b11110}, {3'd5, 5'b11100}, {3'd5, 5'b11000},
    {3'd5, 5'b10000}, {3'd5, 5'b00000}, {3'd5, 5'b00001}, {3'd5, 5'b00011},
    {3'd5, 5'b00111}, {3'd5, 5'b01111}
  };

  typedef enum logic [1:0] {
    CFG_DOT_LIMIT  = 2'd0,
    CFG_LETTER_GAP = 2'd1,
    CFG_WORD_GAP   = 2'd2
  } mkd_cfg_index_t;

  typedef struct packed {
    logic space_mark;
    logic release_edge;
    logic dash;
    logic gap_over;
  } mkd_event_t;

  typedef struct packed {
    logic              char_valid;
    logic [CodeW-1:0]  char_code;
    logic              space_before;
    logic [CountW-1:0] text_length;
  } mkd_letter_t;

  typedef struct packed {
    logic        tone_on;
    mkd_letter_t letter;
  } mkd_result_t;

  function automatic logic [CodeW-1:0] mkd_decode(input logic [2:0] len,
                                                  input logic [4:0] bits);
    logic [CodeW-1:0] code;
    code = UnknownCode;
    for (int i = 0; i < CodeEntries; i++) begin
      if (CodeTable[i] == {len, bits}) begin
        code = (i < LetterEntries) ? CodeW'(LetterBase + CodeW'(i))
                                   : CodeW'(DigitBase + CodeW'(i - LetterEntries));
      end
    end
    return code;
  endfunction

endpackage

// ----- rtl/mkd_timer.sv -----
module mkd_timer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  logic                             key_down,
  input  logic [mkd_pkg::DotLimitW-1:0]    dot_limit,
  input  logic [mkd_pkg::LetterGapW-1:0]   letter_gap,
  input  logic [mkd_pkg::WordGapW-1:0]     word_gap,
  output mkd_pkg::mkd_event_t              ev
);
  import mkd_pkg::*;

  logic [TickW-1:0] press_ticks;
  logic [TickW-1:0] gap_ticks;
  logic             key_was_down;
  logic             seen_first_press;
  logic [TickW-1:0] gap_inc;

  // Both counters stick at their ceiling.
  assign gap_inc = (gap_ticks == TickMax) ? gap_ticks : gap_ticks + 1'b1;

  always_comb begin
    ev.space_mark   = key_down && !key_was_down && seen_first_press &&
                      (gap_ticks > word_gap);
    ev.release_edge = !key_down && key_was_down;
    ev.dash         = press_ticks >= TickW'(dot_limit);
    ev.gap_over     = !key_down && !key_was_down && (gap_inc > TickW'(letter_gap));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_ticks      <= '0;
      gap_ticks        <= '0;
      key_was_down     <= 1'b0;
      seen_first_press <= 1'b0;
    end else if (step) begin
      key_was_down <= key_down;
      if (key_down) begin
        seen_first_press <= 1'b1;
        if (!key_was_down) begin
          press_ticks <= TickW'(1);
        end else if (press_ticks != TickMax) begin
          press_ticks <= press_ticks + 1'b1;
        end
      end else if (key_was_down) begin
        press_ticks <= '0;
        gap_ticks   <= '0;
      end else begin
        gap_ticks <= gap_inc;
      end
    end
  end

endmodule

// ----- rtl/mkd_letter.sv -----
module mkd_letter #(
  parameter int SYMBOL_SLOTS = mkd_pkg::SymbolSlotsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 erase,
  input  mkd_pkg::mkd_event_t  ev,
  output mkd_pkg::mkd_letter_t res
);
  import mkd_pkg::*;

  localparam int SymCountW = $clog2(SYMBOL_SLOTS + 1);

  logic [SYMBOL_SLOTS-1:0] symbol_pattern, symbol_pattern_next;
  logic [SymCountW-1:0]    symbol_count, symbol_count_next;
  logic                    symbol_pending, symbol_pending_next;
  logic                    space_pending, space_pending_next;
  logic [CountW-1:0]       char_count, char_count_next;
  logic [CountW-1:0]       count_mid;
  logic                    room;
  logic [CodeW-1:0]        letter;

  assign room = ({1'b0, char_count} + 9'd2) <= 9'(MessageCapacity);

  // Patterns longer than any table entry cannot match.
  assign letter = (symbol_count <= SymCountW'(MaxCodeLen))
                ? mkd_decode(symbol_count[2:0], symbol_pattern[4:0]) : UnknownCode;

  always_comb begin
    symbol_pattern_next = symbol_pattern;
    symbol_count_next   = symbol_count;
    symbol_pending_next = symbol_pending;
    space_pending_next  = space_pending;
    count_mid           = char_count;
    res                 = '0;
    if (ev.space_mark) begin
      space_pending_next = 1'b1;
    end
    if (ev.release_edge) begin
      if (symbol_count < SymCountW'(SYMBOL_SLOTS)) begin
        for (int i = 0; i < SYMBOL_SLOTS; i++) begin
          if (symbol_count == SymCountW'(i)) begin
            symbol_pattern_next[i] = ev.dash;
          end
        end
        symbol_count_next = symbol_count + 1'b1;
      end
      symbol_pending_next = 1'b1;
    end
    if (ev.gap_over && symbol_pending) begin
      if (room) begin
        if (space_pending) begin
          count_mid          = count_mid + 1'b1;
          res.space_before   = 1'b1;
          space_pending_next = 1'b0;
        end
        count_mid      = count_mid + 1'b1;
        res.char_valid = 1'b1;
        res.char_code  = letter;
      end
      symbol_pattern_next = '0;
      symbol_count_next   = '0;
      symbol_pending_next = 1'b0;
    end
    char_count_next = (erase && count_mid != '0) ? count_mid - 1'b1 : count_mid;
    res.text_length = char_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_pattern <= '0;
      symbol_count   <= '0;
      symbol_pending <= 1'b0;
      space_pending  <= 1'b0;
      char_count     <= '0;
    end else if (step) begin
      symbol_pattern <= symbol_pattern_next;
      symbol_count   <= symbol_count_next;
      symbol_pending <= symbol_pending_next;
      space_pending  <= space_pending_next;
      char_count     <= char_count_next;
    end
  end

endmodule

// ----- rtl/morse_key_decoder_top.sv -----
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_stall    key_down, erase
// out      source     out_valid / out_stall  tone_on, char_valid, char_code,
//                                            space_before, text_length
// cfg      sink       cfg_write              cfg_index, cfg_data
//
// One word is taken per clock cycle while in_stall is low; with the output register
// free its result is ready in the cycle after it is accepted.
// The output register is backed by a one-word skid stage: while the output stalls one
// more word is taken and then in_stall rises; the cycle that drains the skid stage
// takes no new word.
// in_stall is high only while the skid stage holds a word; it is a plain register output.
// Reset (rst, synchronous, active high) clears all key state, the message count and the
// handshake, and loads the default timing registers.
module morse_key_decoder_top #(
  parameter int SYMBOL_SLOTS = mkd_pkg::SymbolSlotsDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          key_down,
  input  logic                          erase,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          tone_on,
  output logic                          char_valid,
  output logic [mkd_pkg::CodeW-1:0]     char_code,
  output logic                          space_before,
  output logic [mkd_pkg::CountW-1:0]    text_length,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [mkd_pkg::CfgDataW-1:0]  cfg_data
);
  import mkd_pkg::*;

  // Timing registers, to be written only while the decoder is idle; the block does not enforce this.
  logic [DotLimitW-1:0]  dot_limit;
  logic [LetterGapW-1:0] letter_gap;
  logic [WordGapW-1:0]   word_gap;

  logic        accept;
  logic        take;
  mkd_event_t  ev;
  mkd_letter_t letter;
  mkd_result_t result_new;
  mkd_result_t out_word;
  mkd_result_t skid_word;
  logic        skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_limit  <= DotLimitReset;
      letter_gap <= LetterGapReset;
      word_gap   <= WordGapReset;
    end else if (cfg_write) begin
      unique case (mkd_cfg_index_t'(cfg_index))
        CFG_DOT_LIMIT:  dot_limit  <= cfg_data[DotLimitW-1:0];
        CFG_LETTER_GAP: letter_gap <= cfg_data[LetterGapW-1:0];
        CFG_WORD_GAP:   word_gap   <= cfg_data[WordGapW-1:0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid && !in_stall;
  assign take   = out_valid && !out_stall;

  // The key timer turns each tick into press and gap events.
  mkd_timer u_timer (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .key_down   (key_down),
    .dot_limit  (dot_limit),
    .letter_gap (letter_gap),
    .word_gap   (word_gap),
    .ev         (ev)
  );

  // The letter unit collects symbols, looks up the letter and keeps the message count.
  mkd_letter #(
    .SYMBOL_SLOTS (SYMBOL_SLOTS)
  ) u_letter (
    .clk   (clk),
    .rst   (rst),
    .step  (accept),
    .erase (erase),
    .ev    (ev),
    .res   (letter)
  );

  assign result_new.tone_on = key_down;
  assign result_new.letter  = letter;

  // Output register plus skid stage. A new word goes straight to the output
  // register when that is free or being emptied, otherwise it parks in the skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || take) begin
        out_word  <= result_new;
        out_valid <= 1'b1;
      end else begin
        skid_word  <= result_new;
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  assign in_stall     = skid_valid;
  assign tone_on      = out_word.tone_on;
  assign char_valid   = out_word.letter.char_valid;
  assign char_code    = out_word.letter.char_code;
  assign space_before = out_word.letter.space_before;
  assign text_length  = out_word.letter.text_length;

endmodule

// ----- rtl/mkd_checker.sv -----
`include "morse_key_decoder_top_assert.svh"

module mkd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       key_down,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       tone_on,
  input logic                       char_valid,
  input logic [mkd_pkg::CodeW-1:0]  char_code,
  input logic                       space_before,
  input logic [mkd_pkg::CountW-1:0] text_length
);

  // A word accepted while the output is free appears there in the next cycle.
  `MKD_ASSERT_NEXT(a_tone_follows, in_valid && !in_stall && (!out_valid || !out_stall), out_valid && tone_on == $past(key_down), "accepted word did not reach the output")

  // Without a letter the letter fields stay clear.
  `MKD_ASSERT_NOW(a_no_letter_clear, out_valid && !char_valid, char_code == '0 && !space_before, "letter fields set without a letter")

  // A letter after a word space adds two characters, so even an erase in the
  // same tick leaves the message non-empty.
  `MKD_ASSERT_NOW(a_letter_counted, out_valid && char_valid && space_before, text_length != '0, "spaced letter left an empty message")

  // A stalled result holds.
  `MKD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(char_code) && $stable(text_length), "stalled result changed")

endmodule

bind morse_key_decoder_top mkd_checker u_checker (.*);

// ----- test/morse_checker.sv -----
`timescale 1ns / 1ps

module morse_checker #(
  parameter int SYMBOL_SLOTS = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         key_down,
  input  logic                         erase,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         tone_on,
  input  logic                         char_valid,
  input  logic [mkd_pkg::CodeW-1:0]    char_code,
  input  logic                         space_before,
  input  logic [mkd_pkg::CountW-1:0]   text_length,
  input  logic                         cfg_write,
  input  logic [1:0]                   cfg_index,
  input  logic [mkd_pkg::CfgDataW-1:0] cfg_data,
  output int                           fails,
  output int                           waiting,
  output int                           ticks_checked,
  output int                           letters_out,
  output int                           unknown_out,
  output int                           spaces_out,
  output int                           letters_lost
);
  import mkd_pkg::*;

  typedef struct packed {
    logic              tone;
    logic              valid;
    logic [CodeW-1:0]  code;
    logic              space;
    logic [CountW-1:0] length;
  } tick_result_t;

  tick_result_t expected_ticks[$];
  tick_result_t want, fresh;

  // Keyer state as the block should hold it.
  logic [11:0]             held_ticks, idle_ticks;
  logic                    key_held, letter_open, pressed_once, space_owed;
  logic [SYMBOL_SLOTS-1:0] dash_mask;
  int                      sym_count;
  logic [7:0]              msg_count;
  logic [11:0]             dot_limit, letter_gap, word_gap;

  // Symbols are read as decimal digits in the order keyed: 1 is a dot, 2 a dash.
  function automatic logic [7:0] morse_lookup(input logic [SYMBOL_SLOTS-1:0] dashes,
                                              input int count);
    int digits;
    digits = 0;
    if (count > 5) return "a";
    for (int i = 0; i < count; i++) digits = digits * 10 + (dashes[i] ? 2 : 1);
    case (digits)
      12: return "A";    2111: return "B";  2121: return "C";  211: return "D";
      1: return "E";     1121: return "F";  221: return "G";   1111: return "H";
      11: return "I";    1222: return "J";  212: return "K";   1211: return "L";
      22: return "M";    21: return "N";    222: return "O";   1221: return "P";
      2212: return "Q";  121: return "R";   111: return "S";   2: return "T";
      112: return "U";   1112: return "V";  122: return "W";   2112: return "X";
      2122: return "Y";  2211: return "Z";
      22222: return "0"; 12222: return "1"; 11222: return "2"; 11122: return "3";
      11112: return "4"; 11111: return "5"; 21111: return "6"; 22111: return "7";
      22211: return "8"; 22221: return "9";
      default: return "a";
    endcase
  endfunction

  task automatic step_keyer(input logic down, input logic rub, output tick_result_t r);
    logic [7:0] sym;
    r = '0;
    if (down) begin
      if (!key_held) begin
        if (pressed_once && idle_ticks > word_gap) space_owed = 1'b1;
        pressed_once = 1'b1;
        held_ticks = 12'd1;
      end else if (held_ticks != 12'hFFF) begin
        held_ticks = held_ticks + 12'd1;
      end
    end else if (key_held) begin
      if (sym_count < SYMBOL_SLOTS) begin
        if (held_ticks >= dot_limit) dash_mask[sym_count] = 1'b1;
        sym_count++;
      end
      letter_open = 1'b1;
      held_ticks = '0;
      idle_ticks = '0;
    end else begin
      if (idle_ticks != 12'hFFF) idle_ticks = idle_ticks + 12'd1;
      if (letter_open && idle_ticks > letter_gap) begin
        sym = morse_lookup(dash_mask, sym_count);
        if (int'(msg_count) + 2 <= MessageCapacity) begin
          if (space_owed) begin
            msg_count++;
            r.space = 1'b1;
            space_owed = 1'b0;
            spaces_out++;
          end
          msg_count++;
          r.valid = 1'b1;
          r.code = sym[6:0];
          letters_out++;
          if (sym == "a") unknown_out++;
        end else begin
          letters_lost++;
        end
        dash_mask = '0;
        sym_count = 0;
        letter_open = 1'b0;
      end
    end
    key_held = down;
    if (rub && msg_count != 8'd0) msg_count--;
    r.tone = down;
    r.length = msg_count;
  endtask

  task automatic check_field(input string what, input logic [7:0] got,
                             input logic [7:0] want_v);
    if (got !== want_v) begin
      $display("%0t ns: word %0d, %s expected %0d, got %0d",
               $time, ticks_checked, what, want_v, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_ticks = '0;
      idle_ticks = '0;
      key_held = 1'b0;
      letter_open = 1'b0;
      pressed_once = 1'b0;
      space_owed = 1'b0;
      dash_mask = '0;
      sym_count = 0;
      msg_count = '0;
      dot_limit = 12'd30;
      letter_gap = 12'd50;
      word_gap = 12'd150;
      expected_ticks.delete();
      waiting <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        ticks_checked++;
        if (expected_ticks.size() == 0) begin
          $display("%0t ns: result word %0d arrived with no tick waiting for it",
                   $time, ticks_checked);
          fails++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("tone_on", 8'(tone_on), 8'(want.tone));
          check_field("char_valid", 8'(char_valid), 8'(want.valid));
          check_field("char_code", 8'(char_code), 8'(want.code));
          check_field("space_before", 8'(space_before), 8'(want.space));
          check_field("text_length", text_length, want.length);
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_DOT_LIMIT:  dot_limit = {2'b00, cfg_data[9:0]};
          CFG_LETTER_GAP: letter_gap = {2'b00, cfg_data[9:0]};
          CFG_WORD_GAP:   word_gap = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        step_keyer(key_down, erase, fresh);
        expected_ticks.push_back(fresh);
      end
      waiting <= expected_ticks.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

// Drives the Morse key decoder with sampling ticks shaped as real keying:
// presses and gaps are sized around the programmed dot, letter and word
// thresholds, so that letters, word spaces, unknown patterns and symbol
// overflow all occur. The checker beside the block predicts every result word.
module tb_top;
  import mkd_pkg::*;

  localparam int Slots = 9;
  // Longest quiet stretch is a sender gap plus a receiver stall, well under this.
  localparam int QuietLimit = 1000;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                key_down;
  logic                erase;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                tone_on;
  logic                char_valid;
  logic [CodeW-1:0]    char_code;
  logic                space_before;
  logic [CountW-1:0]   text_length;
  logic                cfg_write;
  logic [1:0]          cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  int fails, waiting, ticks_checked, letters_out, unknown_out, spaces_out, letters_lost;

  // Shadow of the timing registers, used only to shape the keying.
  int dot_now, letter_now, word_now;
  int erase_pct;
  int settings_used = 0;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;
  int stall_left = 0;
  int stall_draw;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  morse_key_decoder_top #(.SYMBOL_SLOTS(Slots)) dut (.*);

  morse_checker #(.SYMBOL_SLOTS(Slots)) checker_i (.*);

  // The receiver draws a fresh stall length after every word it takes. Now and
  // then it switches into a calm stretch in which it never stalls at all.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_stall) begin
      out_stall <= (stall_left > 1);
      stall_left <= stall_left - 1;
    end else if (out_valid) begin
      if ($urandom_range(49) == 0) receiver_calm = !receiver_calm;
      stall_draw = receiver_calm ? 0 : $urandom_range(14);
      if (stall_draw != 0) out_stall <= 1'b1;
      stall_left <= stall_draw;
    end
  end

  // Watchdog: the run is abandoned if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("%0t ns: no word accepted for %0d cycles", $time, QuietLimit);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One tick word. The sender first idles for its drawn gap, then holds the word
  // until the block takes it. Valid is left high afterwards so that back-to-back
  // words never see it dropped and raised within one time step.
  task automatic send_tick(input logic down, input logic rub);
    int pause;
    pause = sender_calm ? 0 : $urandom_range(14);
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    key_down <= down;
    erase <= rub;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic erase_roll();
    return $urandom_range(99) < erase_pct;
  endfunction

  task automatic key_press(input int n);
    repeat (n) send_tick(1'b1, erase_roll());
  endtask

  // The count includes the release tick itself.
  task automatic key_gap(input int n);
    repeat (n) send_tick(1'b0, erase_roll());
  endtask

  // Dots often sit one tick below the limit, dashes on it or just above.
  function automatic int press_len(input logic dash);
    int n;
    if (dash) n = dot_now + $urandom_range(2);
    else if (dot_now <= 1) n = 1;
    else if ($urandom_range(1) == 1) n = dot_now - 1;
    else n = $urandom_range(dot_now - 1, 1);
    return (n < 1) ? 1 : n;
  endfunction

  // A gap inside a letter, often the longest one that does not close the letter.
  function automatic int inner_gap();
    if ($urandom_range(9) < 4) return letter_now + 1;
    return $urandom_range(letter_now + 1, 1);
  endfunction

  // The gap after a letter: mostly just past the letter gap, sometimes long
  // enough for a word space, sometimes exactly one tick short of one.
  function automatic int letter_end();
    int pick, k;
    pick = $urandom_range(99);
    if (pick < 25) k = word_now + 2 + $urandom_range(1);
    else if (pick < 35) k = word_now + 1;
    else k = letter_now + 2 + $urandom_range(2);
    return (k < letter_now + 2) ? letter_now + 2 : k;
  endfunction

  // Keys n symbols; bit i of syms set makes symbol i a dash.
  task automatic key_code(input logic [15:0] syms, input int n);
    for (int i = 0; i < n; i++) begin
      key_press(press_len(syms[i]));
      if (i != n - 1) key_gap(inner_gap());
    end
  endtask

  // Mostly well-formed letters of random content; a few are over-long patterns
  // and a few are plain noise on the key input.
  task automatic send_letter();
    int pick;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat ($urandom_range(16, 4)) send_tick(1'($urandom_range(1)), erase_roll());
    end else begin
      if (pick < 88) key_code(16'($urandom), $urandom_range(5, 1));
      else if (pick < 95) key_code(16'($urandom), $urandom_range(Slots, 6));
      else key_code(16'($urandom), $urandom_range(Slots + 3, Slots + 1));
      key_gap(letter_end());
    end
    if ($urandom_range(4) == 0) sender_calm = !sender_calm;
  endtask

  // Registers are written one per cycle with the write enable held high throughout.
  task automatic set_timing(input int dot, input int letter, input int word);
    dot_now = dot;
    letter_now = letter;
    word_now = word;
    cfg_write <= 1'b1;
    cfg_index <= CFG_DOT_LIMIT;
    cfg_data <= CfgDataW'(dot);
    @(posedge clk);
    cfg_index <= CFG_LETTER_GAP;
    cfg_data <= CfgDataW'(letter);
    @(posedge clk);
    cfg_index <= CFG_WORD_GAP;
    cfg_data <= CfgDataW'(word);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Waits until every predicted word has been seen, plus a short margin, so that
  // the block is idle before the timing registers change.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    key_down <= 1'b0;
    erase <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_DOT_LIMIT;
    cfg_data <= '0;
    erase_pct = 0;
    dot_now = 30;
    letter_now = 50;
    word_now = 150;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed keying on the reset timings. An erase on the empty message comes
    // first. Then a dot one tick under the limit, a gap that just fails to close
    // the letter, a dash exactly on the limit and a gap that decodes the letter.
    // The following silence runs one tick past the word gap, so the next letter
    // should carry a word space.
    send_tick(1'b0, 1'b1);
    key_press(29);
    key_gap(51);
    key_press(30);
    key_gap(52);
    key_gap(100);
    key_press(1);
    key_gap(52);
    settle();

    // Directed keying on short timings: a pattern with no table entry, a digit,
    // more symbols than the pattern can hold, an erase in the very tick a letter
    // is appended, and an erase while the key is held.
    set_timing(2, 1, 3);
    key_code(16'h0000, 6);
    key_gap(3);
    key_code(16'h001F, 5);
    key_gap(3);
    key_code(16'h0FFF, 12);
    key_gap(6);
    key_code(16'h0002, 2);
    key_gap(2);
    send_tick(1'b0, 1'b1);
    key_press(1);
    send_tick(1'b1, 1'b1);
    key_gap(3);
    settle();

    // Random letters on modest timings with occasional erases.
    erase_pct = 3;
    set_timing(3, 2, 6);
    repeat (8) send_letter();
    settle();

    // All thresholds at one: every press is a dash.
    erase_pct = 5;
    set_timing(1, 1, 1);
    repeat (10) send_letter();
    settle();

    // All thresholds at zero: a letter closes on the first idle tick.
    erase_pct = 4;
    set_timing(0, 0, 0);
    repeat (10) send_letter();
    settle();

    erase_pct = 2;
    set_timing(6, 4, 20);
    repeat (4) send_letter();
    settle();

    // Largest dot limit and word gap: every press is a dot, and no gap here is
    // long enough for a word space.
    erase_pct = 0;
    set_timing(1023, 2, 4095);
    key_press(40);
    key_gap(2);
    key_press(1);
    key_gap(4);
    key_press(3);
    key_gap(4);
    settle();

    // Fill the message with short letters, about half of them after a word
    // space, until it is full, so that letters are lost and a pending space has
    // to wait. Two erases then make room for one more letter.
    set_timing(2, 0, 1);
    repeat (100) begin
      key_press(1);
      key_gap(($urandom_range(1) == 0) ? 3 : 2);
    end
    repeat (2) send_tick(1'b0, 1'b1);
    key_press(1);
    key_gap(2);
    settle();

    $display("Checked %0d result words: %0d letters appended (%0d unknown, %0d after a space)",
             ticks_checked, letters_out, unknown_out, spaces_out);
    $display("and %0d lost to a full message, over %0d timing settings.",
             letters_lost, settings_used + 1);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
